// ===== sv/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== sv/stti_pkg.sv =====
// ----------------------------------------------------------------------------
// stti_pkg
// shared types and constants of the sorted time table interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package stti_pkg;

	localparam int STTI_DEPTH = 64;

	localparam logic [1:0] REG_MAX_ENTRIES    = 2'd0;
	localparam logic [1:0] REG_DEFAULT_ENABLE = 2'd1;
	localparam logic [1:0] REG_DEFAULT_VALUE  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DEFAULT = 2'd1;
	localparam logic [1:0] ST_BEFORE  = 2'd2;
	localparam logic [1:0] ST_AFTER   = 2'd3;

	localparam logic [6:0] MAX_ENTRIES_RESET = 7'd64;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_EVICT,
		S_MUL,
		S_DIV,
		S_FIN,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== sv/sorted_time_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// sorted_time_table_interpolator
// sorted (time, value) table with step or linear interpolation on query
// ----------------------------------------------------------------------------
// One request at a time. The table lives in a circular buffer memory (one
// read port, one write port, registered read) so evicting the oldest entry
// only moves a head pointer. The position search reads and compares the
// entries in order until one is not below the request time. An insert then
// shifts the entries above its place one at a time (read, then write),
// writes the pair, and evicts one entry per step until the count fits the
// limit. A linear query adds a 32x32 multiply step and a 64-step restoring
// divider. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_time_table_interpolator
	import stti_pkg::*;
#(
	parameter int DEPTH = STTI_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic               kind,
	input  wire logic signed [31:0] sample_time,
	input  wire logic signed [31:0] sample_value,
	input  wire logic               interpolate,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output logic signed [31:0]      result_value,
	output logic [1:0]              status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

	logic signed [31:0] times_mem [DEPTH];
	logic signed [31:0] values_mem [DEPTH];

	state_t state_q, state_d;

	logic [6:0]         max_entries_q;
	logic               default_enable_q;
	logic signed [31:0] default_value_q;

	logic [AW-1:0]      head_q;
	logic [CW-1:0]      count_q, idx_q, pos_q;
	logic               kind_q, lin_q, hit_q, at_end_q;
	logic signed [31:0] t_q, v_q, prev_t_q, prev_v_q, rd_t_q, rd_v_q;
	logic [63:0]        quo_q;
	logic [31:0]        rem_q;
	logic [31:0]        den_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic signed [31:0] res_val_q;
	logic [1:0]         res_st_q;
	logic               rsp_valid_q;
	logic signed [31:0] result_value_q;
	logic [1:0]         status_q;

	logic          mem_re, mem_we;
	logic [CW-1:0] ra_log, wa_log;
	logic [AW-1:0] mem_ra, mem_wa;
	logic signed [31:0] mem_wt, mem_wv;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(DEPTH))
			s = s - (CW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	logic [AW-1:0] head_inc;
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	logic [LW-1:0] lim, count_l;
	assign count_l = LW'(count_q);
	assign lim = (LW'(max_entries_q) > DEPTH_L) ? DEPTH_L : LW'(max_entries_q);

	// interpolation operands, both differences are below 2^32
	logic [31:0] num_w, den_w, mag_w;
	logic [32:0] dv_w;
	assign num_w = t_q - prev_t_q;
	assign den_w = rd_t_q - prev_t_q;
	assign dv_w  = {rd_v_q[31], rd_v_q} - {prev_v_q[31], prev_v_q};
	assign mag_w = dv_w[32] ? 32'(-dv_w) : dv_w[31:0];

	logic [32:0] div_sh;
	logic        div_ge;
	assign div_sh = {rem_q, quo_q[63]};
	assign div_ge = div_sh >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			times_mem[mem_wa]  <= mem_wt;
			values_mem[mem_wa] <= mem_wv;
		end
		if (mem_re) begin
			rd_t_q <= times_mem[mem_ra];
			rd_v_q <= values_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		ra_log    = idx_q;
		wa_log    = idx_q;
		mem_wt    = rd_t_q;
		mem_wv    = rd_v_q;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid)
					state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (idx_q == count_q) begin
					state_d = S_DECIDE;
				end else begin
					mem_re  = 1'b1;
					state_d = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				state_d = (rd_t_q < t_q) ? S_SCAN_RD : S_DECIDE;
			end
			S_DECIDE: begin
				if (!kind_q) begin
					if (hit_q)
						state_d = S_IDLE;
					else if (count_q == DEPTH_C && idx_q == '0)
						state_d = S_EVICT;
					else
						state_d = S_SHIFT_RD;
				end else if (!at_end_q && !hit_q && idx_q != '0 && lin_q) begin
					state_d = S_MUL;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHIFT_RD: begin
				if (idx_q == pos_q) begin
					state_d = S_PUT;
				end else begin
					mem_re  = 1'b1;
					ra_log  = idx_q - 1'b1;
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				mem_we  = 1'b1;
				state_d = S_SHIFT_RD;
			end
			S_PUT: begin
				mem_we  = 1'b1;
				wa_log  = pos_q;
				mem_wt  = t_q;
				mem_wv  = v_q;
				state_d = S_EVICT;
			end
			S_EVICT: begin
				if (count_l <= lim)
					state_d = S_IDLE;
			end
			S_MUL: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (cnt_q == '1)
					state_d = S_FIN;
			end
			S_FIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign mem_ra = phys(head_q, ra_log);
	assign mem_wa = phys(head_q, wa_log);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q    <= MAX_ENTRIES_RESET;
			default_enable_q <= 1'b0;
			default_value_q  <= '0;
			head_q           <= '0;
			count_q          <= '0;
			rsp_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_ENTRIES:    max_entries_q    <= cfg_data[6:0];
					REG_DEFAULT_ENABLE: default_enable_q <= cfg_data[0];
					REG_DEFAULT_VALUE:  default_value_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready))
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp_ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_DECIDE: begin
					// full table: drop the oldest before making room
					if (!kind_q && !hit_q && count_q == DEPTH_C && idx_q != '0) begin
						head_q  <= head_inc;
						count_q <= count_q - 1'b1;
					end
				end
				S_PUT: begin
					count_q <= count_q + 1'b1;
				end
				S_EVICT: begin
					if (count_l > lim) begin
						head_q  <= head_inc;
						count_q <= count_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q   <= kind;
				t_q      <= sample_time;
				v_q      <= sample_value;
				lin_q    <= interpolate;
				idx_q    <= '0;
				prev_t_q <= '0;
				prev_v_q <= '0;
			end
			S_SCAN_RD: begin
				if (idx_q == count_q) begin
					at_end_q <= 1'b1;
					hit_q    <= 1'b0;
				end
			end
			S_SCAN_CMP: begin
				at_end_q <= 1'b0;
				hit_q    <= (rd_t_q == t_q);
				if (rd_t_q < t_q) begin
					prev_t_q <= rd_t_q;
					prev_v_q <= rd_v_q;
					idx_q    <= idx_q + 1'b1;
				end
			end
			S_DECIDE: begin
				if (!kind_q) begin
					if (count_q == DEPTH_C) begin
						pos_q <= idx_q - 1'b1;
						idx_q <= count_q - 1'b1;
					end else begin
						pos_q <= idx_q;
						idx_q <= count_q;
					end
				end else begin
					if (hit_q) begin
						res_val_q <= rd_v_q;
						res_st_q  <= ST_OK;
					end else if ((at_end_q && (count_q == '0 || lin_q)) ||
						(!at_end_q && idx_q == '0)) begin
						res_val_q <= default_enable_q ? default_value_q : '0;
						res_st_q  <= default_enable_q ? ST_DEFAULT :
							(at_end_q ? ST_AFTER : ST_BEFORE);
					end else begin
						res_val_q <= prev_v_q;
						res_st_q  <= ST_OK;
					end
				end
			end
			S_SHIFT_WR: begin
				idx_q <= idx_q - 1'b1;
			end
			S_MUL: begin
				quo_q <= 64'(num_w * mag_w);
				den_q <= den_w;
				neg_q <= dv_w[32];
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= div_ge ? 32'(div_sh - {1'b0, den_q}) : div_sh[31:0];
				quo_q <= {quo_q[62:0], div_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			S_FIN: begin
				res_val_q <= neg_q ? prev_v_q - $signed(quo_q[31:0])
					: prev_v_q + $signed(quo_q[31:0]);
				res_st_q  <= ST_OK;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					result_value_q <= res_val_q;
					status_q       <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_value = result_value_q;
	assign status       = status_q;

endmodule

`default_nettype wire

// ===== sv/stti_checker.sv =====
// ----------------------------------------------------------------------------
// stti_checker
// port-level checks of the sorted time table interpolator
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stti_checker
	import stti_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] result_value,
	input wire logic [1:0]  status
);

	// a pending response keeps its payload
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(result_value))
	// error responses carry a zero value
	`ASSERT_IMPLY(a_err_zero, clk, arst_n, rsp_valid && (status == ST_BEFORE || status == ST_AFTER), result_value == 32'd0)
	// a request that is taken leaves the block busy, not ready for another
	`ASSERT_NEXT(a_busy, clk, arst_n, req_valid && req_ready, !req_ready)
	// a response never appears in the cycle after a request is taken
	`ASSERT_NEXT(a_no_fast_rsp, clk, arst_n, req_valid && req_ready && !rsp_valid, !rsp_valid)

endmodule

bind sorted_time_table_interpolator stti_checker u_stti_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_ready    (req_ready),
	.rsp_valid    (rsp_valid),
	.rsp_ready    (rsp_ready),
	.result_value (result_value),
	.status       (status)
);

`default_nettype wire

// ===== test/sorted_time_table_interpolator_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_time_table_interpolator_tb
// drives inserts and queries with random handshake gaps, predicts every query
// answer from a local copy of the sorted table and checks each response
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
	logic signed [31:0] value;
	logic [1:0]         st;
} answer_t;

class table_scoreboard;
	int          tab_time[stti_pkg::STTI_DEPTH];
	int          tab_val[stti_pkg::STTI_DEPTH];
	int          count;
	int          limit_reg;
	bit          dflt_en;
	int          dflt_val;
	answer_t     answers[$];
	int          errors;
	int          inserts;
	int          queries;

	function new();
		count = 0;
		limit_reg = 64;
		dflt_en = 0;
		dflt_val = 0;
		errors = 0;
		inserts = 0;
		queries = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] d);
		case (idx)
			stti_pkg::REG_MAX_ENTRIES: limit_reg = d[6:0];
			stti_pkg::REG_DEFAULT_ENABLE: dflt_en = d[0];
			stti_pkg::REG_DEFAULT_VALUE: dflt_val = d;
			default: ;
		endcase
	endfunction

	function int below(int t);
		int i;
		i = 0;
		while (i < count && tab_time[i] < t)
			i++;
		return i;
	endfunction

	function void drop_oldest();
		if (count == 0)
			return;
		for (int i = 0; i < count - 1; i++) begin
			tab_time[i] = tab_time[i + 1];
			tab_val[i] = tab_val[i + 1];
		end
		count--;
	endfunction

	function void put_at(int p, int t, int v);
		for (int i = count; i > p; i--) begin
			tab_time[i] = tab_time[i - 1];
			tab_val[i] = tab_val[i - 1];
		end
		tab_time[p] = t;
		tab_val[p] = v;
		count++;
	endfunction

	function answer_t outside(logic [1:0] err);
		answer_t a;
		a.value = dflt_en ? dflt_val : 0;
		a.st = dflt_en ? stti_pkg::ST_DEFAULT : err;
		return a;
	endfunction

	// note an accepted request and queue its expected answer if it has one
	function void note(bit k, int t, int v, bit lin);
		int lim, p, t0, t1, v0, v1;
		logic [63:0] num, den, mag, q;
		longint dv, r;
		answer_t a;
		if (k == 1'b0) begin
			inserts++;
			lim = limit_reg > stti_pkg::STTI_DEPTH ? stti_pkg::STTI_DEPTH : limit_reg;
			p = below(t);
			if (p < count && tab_time[p] == t)
				return;
			if (count >= stti_pkg::STTI_DEPTH) begin
				// full table: the smallest of old entries and the new one goes
				if (p != 0) begin
					drop_oldest();
					put_at(p - 1, t, v);
				end
			end else begin
				put_at(p, t, v);
			end
			while (count > lim)
				drop_oldest();
			return;
		end
		queries++;
		p = below(t);
		if (p >= count) begin
			if (count > 0 && !lin) begin
				a.value = tab_val[count - 1];
				a.st = stti_pkg::ST_OK;
			end else begin
				a = outside(stti_pkg::ST_AFTER);
			end
		end else if (tab_time[p] == t) begin
			a.value = tab_val[p];
			a.st = stti_pkg::ST_OK;
		end else if (p == 0) begin
			a = outside(stti_pkg::ST_BEFORE);
		end else begin
			t0 = tab_time[p - 1];
			t1 = tab_time[p];
			v0 = tab_val[p - 1];
			v1 = tab_val[p];
			r = v0;
			if (lin) begin
				num = longint'(t) - longint'(t0);
				den = longint'(t1) - longint'(t0);
				dv = longint'(v1) - longint'(v0);
				mag = dv < 0 ? -dv : dv;
				q = (num * mag) / den;
				r = dv < 0 ? r - longint'(q) : r + longint'(q);
			end
			a.value = r[31:0];
			a.st = stti_pkg::ST_OK;
		end
		answers.insert(answers.size(), a);
	endfunction

	function void check(logic signed [31:0] rv, logic [1:0] st);
		answer_t a;
		if (answers.size() == 0) begin
			$error("response with no query outstanding: value %0d status %0d", rv, st);
			errors++;
			return;
		end
		a = answers.pop_front();
		if (rv !== a.value) begin
			$error("result_value expected %0d actual %0d", a.value, rv);
			errors++;
		end
		if (st !== a.st) begin
			$error("status expected %0d actual %0d", a.st, st);
			errors++;
		end
	endfunction
endclass

module sorted_time_table_interpolator_tb;
	import stti_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               req_valid;
	logic               req_ready;
	logic               kind;
	logic signed [31:0] sample_time;
	logic signed [31:0] sample_value;
	logic               interpolate;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0]         status;

	table_scoreboard sb;
	int send_idle;
	int recv_idle;
	int recv_hold = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int quiet_cycles = 0;
	int base_time;

	sorted_time_table_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_ready(req_ready),
		.kind(kind), .sample_time(sample_time), .sample_value(sample_value),
		.interpolate(interpolate),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.result_value(result_value), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// monitor: sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note(kind, sample_time, sample_value, interpolate);
			if (rsp_valid && rsp_ready)
				sb.check(result_value, status);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("FAIL sorted_time_table_interpolator");
				$finish;
			end
		end
	end

	// response side: random back-pressure plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			recv_hold <= 1500;
			rsp_ready <= 1'b0;
		end else if (recv_hold > 0) begin
			rsp_ready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send(bit k, int t, int v, bit lin);
		while ($urandom_range(99) < send_idle) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		kind = k;
		sample_time = t;
		sample_value = v;
		interpolate = lin;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid = 1'b0;
		while (sb.answers.size() != 0)
			@(negedge clk);
		// an insert may still be shifting the table
		repeat (400) @(negedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [31:0] d);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_request();
		int t;
		if ($urandom_range(9) == 0)
			t = $urandom;
		else
			t = base_time + $urandom_range(300);
		send($urandom_range(99) < 55 ? 1'b0 : 1'b1, t, $urandom, 1'($urandom_range(1)));
	endtask

	task automatic run_phase(int n, int sidle, int ridle, bit pressure);
		send_idle = sidle;
		recv_idle = ridle;
		base_time = $urandom_range(2000) - 1000;
		if (pressure)
			hold_asks++;
		for (int i = 0; i < n; i++)
			random_request();
		settle();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_ENTRIES;
		cfg_data = '0;
		req_valid = 1'b0;
		kind = 1'b0;
		sample_time = '0;
		sample_value = '0;
		interpolate = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		base_time = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, extremes, hits, between, duplicate
		send(1'b1, 0, 0, 1'b0);
		send(1'b1, 5, 0, 1'b1);
		send(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
		send(1'b0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
		send(1'b0, 0, 32'h0001_0000, 1'b0);
		send(1'b0, 0, 32'h1234_5678, 1'b0);
		send(1'b1, 0, 0, 1'b1);
		send(1'b1, 32'sh8000_0000, 0, 1'b0);
		send(1'b1, 32'sh7fff_ffff, 0, 1'b1);
		send(1'b1, -1, 32'hffff_ffff, 1'b1);
		send(1'b1, -1, 0, 1'b0);
		send(1'b1, 32'sh7fff_fffe, 0, 1'b1);
		send(1'b1, 12345, 0, 1'b1);
		settle();
		cfg_write(REG_DEFAULT_ENABLE, 32'd1);
		cfg_write(REG_DEFAULT_VALUE, 32'h8000_0000);
		send(1'b1, 32'sh7fff_ffff, 0, 1'b1);
		send(1'b1, 32'sh8000_0000, 0, 1'b0);
		settle();
		// lower the limit below the count, evict on next non-duplicate insert
		cfg_write(REG_MAX_ENTRIES, 32'd1);
		send(1'b0, 0, 0, 1'b0);
		send(1'b1, 32'sh8000_0000, 0, 1'b1);
		send(1'b0, 7, 32'h0000_0007, 1'b0);
		send(1'b1, 0, 0, 1'b0);
		send(1'b1, 7, 0, 1'b0);
		settle();
		cfg_write(REG_MAX_ENTRIES, 32'd0);
		send(1'b0, 9, 32'h0000_0009, 1'b0);
		send(1'b1, 9, 0, 1'b0);
		settle();

		// random phases: each idling mode under several settings
		cfg_write(REG_MAX_ENTRIES, 32'd127);
		cfg_write(REG_DEFAULT_ENABLE, 32'd0);
		run_phase(90, 11, 84, 1'b1);
		run_phase(90, 84, 11, 1'b0);
		run_phase(60, 0, 0, 1'b0);
		cfg_write(REG_MAX_ENTRIES, 32'd5);
		cfg_write(REG_DEFAULT_ENABLE, 32'd1);
		cfg_write(REG_DEFAULT_VALUE, 32'h7fff_ffff);
		run_phase(40, 11, 84, 1'b0);
		run_phase(40, 84, 11, 1'b0);
		run_phase(40, 0, 0, 1'b0);
		cfg_write(REG_MAX_ENTRIES, 32'd64);
		cfg_write(REG_DEFAULT_VALUE, $urandom);
		run_phase(40, 0, 0, 1'b0);

		$display("covered %0d inserts and %0d queries over several table limits",
			sb.inserts, sb.queries);
		$display("and default settings, with random gaps and a long response hold-off");
		if (sb.errors == 0 && sb.answers.size() == 0) begin
			$display("PASS sorted_time_table_interpolator");
		end else begin
			$display("FAIL sorted_time_table_interpolator");
		end
		$finish;
	end
endmodule

`default_nettype wire
